// ===== rtl/core/ckb_pkg.sv =====
// Shared types and constants for the color key sprite run blitter.
// Used by ckb_regs, ckb_ctrl, ckb_dp and the top level. No dependencies.
package ckb_pkg;

    localparam int MAX_WIDTH_DEF   = 32;
    localparam int SCREEN_SIZE_DEF = 240;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_MIRROR    = 3'd4;
    localparam logic [2:0] REG_KEY       = 3'd5;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef struct packed {
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [5:0]  sprite_width;
        logic [7:0]  sprite_height;
        logic        mirror;
        logic [15:0] transparent_key;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] x_start;
        logic [7:0] x_end;
        logic [7:0] screen_row;
        logic [7:0] byte_high;
        logic [7:0] byte_low;
        logic       last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEEK_RD,
        ST_SEEK_CHK,
        ST_RUN_RD,
        ST_RUN_CHK,
        ST_WIN,
        ST_DATA_RD,
        ST_DATA_EMIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_col;
        logic rd_start;
        logic col_inc;
        logic start_load;
        logic start_inc;
        logic emit_win;
        logic emit_data;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic scan_go;
        logic col_done;
        logic draw;
        logic emit_ok;
        logic data_last;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/ckb_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on ckb_pkg.
module ckb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ckb_pkg::PADDR_W-1:0] paddr,
    input  logic [ckb_pkg::PDATA_W-1:0] pwdata,
    output logic [ckb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output ckb_pkg::cfg_t               cfg
);
    import ckb_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.sprite_width    <= 6'd32;
            cfg_reg.sprite_height   <= 8'd1;
            cfg_reg.mirror          <= 1'b0;
            cfg_reg.transparent_key <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ORIGIN_X: cfg_reg.origin_x        <= pwdata[9:0];
                REG_ORIGIN_Y: cfg_reg.origin_y        <= pwdata[9:0];
                REG_WIDTH:    cfg_reg.sprite_width    <= pwdata[5:0];
                REG_HEIGHT:   cfg_reg.sprite_height   <= pwdata[7:0];
                REG_MIRROR:   cfg_reg.mirror          <= pwdata[0];
                REG_KEY:      cfg_reg.transparent_key <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X: prdata = {22'd0, cfg_reg.origin_x};
            REG_ORIGIN_Y: prdata = {22'd0, cfg_reg.origin_y};
            REG_WIDTH:    prdata = {26'd0, cfg_reg.sprite_width};
            REG_HEIGHT:   prdata = {24'd0, cfg_reg.sprite_height};
            REG_MIRROR:   prdata = {31'd0, cfg_reg.mirror};
            REG_KEY:      prdata = {16'd0, cfg_reg.transparent_key};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/ckb_ctrl.sv =====
// Scan controller: sequences row load, run search, window and data requests.
// Depends on ckb_pkg.
module ckb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  ckb_pkg::sts_t sts,
    output ckb_pkg::cmd_t cmd
);
    import ckb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.scan_go) state_next = ST_SEEK_RD;
            end
            ST_SEEK_RD: begin
                state_next = sts.col_done ? ST_FLUSH : ST_SEEK_CHK;
            end
            ST_SEEK_CHK: begin
                state_next = sts.draw ? ST_RUN_RD : ST_SEEK_RD;
            end
            ST_RUN_RD: begin
                state_next = sts.col_done ? ST_WIN : ST_RUN_CHK;
            end
            ST_RUN_CHK: begin
                state_next = sts.draw ? ST_RUN_RD : ST_WIN;
            end
            ST_WIN: begin
                if (sts.emit_ok) state_next = ST_DATA_RD;
            end
            ST_DATA_RD: begin
                state_next = ST_DATA_EMIT;
            end
            ST_DATA_EMIT: begin
                if (sts.emit_ok) state_next = sts.data_last ? ST_SEEK_RD : ST_DATA_RD;
            end
            ST_FLUSH: begin
                if (!sts.pend_valid || sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.load = 1'b1;
            ST_SEEK_RD:   cmd.rd_col = !sts.col_done;
            ST_SEEK_CHK: begin
                cmd.col_inc    = 1'b1;
                cmd.start_load = sts.draw;
            end
            ST_RUN_RD:    cmd.rd_col = !sts.col_done;
            ST_RUN_CHK:   cmd.col_inc = sts.draw;
            ST_WIN:       cmd.emit_win = sts.emit_ok;
            ST_DATA_RD:   cmd.rd_start = 1'b1;
            ST_DATA_EMIT: begin
                cmd.emit_data = sts.emit_ok;
                cmd.start_inc = sts.emit_ok;
            end
            ST_FLUSH:     cmd.flush = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/ckb_dp.sv =====
// Datapath: row store, row/column counters, run pointers, pending and output requests.
// Depends on ckb_pkg; driven by ckb_ctrl commands.
module ckb_dp #(
    parameter int MAX_WIDTH   = ckb_pkg::MAX_WIDTH_DEF,
    parameter int SCREEN_SIZE = ckb_pkg::SCREEN_SIZE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ckb_pkg::cfg_t cfg,
    input  ckb_pkg::cmd_t cmd,
    output ckb_pkg::sts_t sts,
    input  logic          s_valid,
    input  logic [15:0]   s_pixel,
    output logic          m_valid,
    input  logic          m_ready,
    output ckb_pkg::res_t m_res
);
    import ckb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [10:0] SCREEN_LIM = 11'(SCREEN_SIZE);

    logic [15:0]   store_mem [MAX_WIDTH];
    logic [15:0]   rd_data_reg;
    logic [CW-1:0] col_count_reg;
    logic [7:0]    row_count_reg;
    logic [7:0]    screen_row_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] start_reg;
    res_t          pend_reg;
    logic          pend_valid_reg;
    res_t          out_reg;
    logic          m_valid_reg;

    logic [5:0]    w6;
    logic [CW-1:0] eff_w;
    logic [7:0]    eff_h;
    logic          accept;
    logic [CW-1:0] cc_base;
    logic [CW-1:0] cc_inc;
    logic          row_end;
    logic [10:0]   py;
    logic          py_on;
    logic [8:0]    row_inc;
    logic [10:0]   x0;
    logic [10:0]   px;
    logic [10:0]   xs;
    logic [10:0]   xe;
    logic [CW-1:0] pos;
    logic [CW-1:0] src;
    logic          rd_en;
    logic          out_free;
    logic          emit;
    logic          flush_go;
    res_t          new_res;
    res_t          flush_res;

    always_comb begin
        if (cfg.sprite_width == 6'd0) begin
            w6 = 6'd1;
        end else if (cfg.sprite_width > 6'(MAX_WIDTH)) begin
            w6 = 6'(MAX_WIDTH);
        end else begin
            w6 = cfg.sprite_width;
        end
    end

    assign eff_w = w6[CW-1:0];
    assign eff_h = (cfg.sprite_height == 8'd0) ? 8'd1 : cfg.sprite_height;

    // row load
    assign accept  = s_valid && cmd.load;
    assign cc_base = (col_count_reg >= eff_w) ? '0 : col_count_reg;
    assign cc_inc  = cc_base + 1'b1;
    assign row_end = (cc_inc == eff_w);
    assign py      = {cfg.origin_y[9], cfg.origin_y} + {3'd0, row_count_reg};
    assign py_on   = !py[10] && (py < SCREEN_LIM);
    assign row_inc = {1'b0, row_count_reg} + 9'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_count_reg <= '0;
                row_count_reg <= (row_inc >= {1'b0, eff_h}) ? 8'd0 : row_inc[7:0];
            end else begin
                col_count_reg <= cc_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && row_end) screen_row_reg <= py[7:0];
    end

    // row store
    assign pos   = cmd.rd_start ? start_reg : col_reg;
    assign src   = cfg.mirror ? (eff_w - 1'b1 - pos) : pos;
    assign rd_en = cmd.rd_col || cmd.rd_start;

    always_ff @(posedge aclk) begin
        if (accept) store_mem[cc_base[AW-1:0]] <= s_pixel;
        if (rd_en) rd_data_reg <= store_mem[src[AW-1:0]];
    end

    // run pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            start_reg <= '0;
        end else begin
            if (accept) begin
                col_reg <= '0;
            end else if (cmd.col_inc) begin
                col_reg <= col_reg + 1'b1;
            end
            if (cmd.start_load) begin
                start_reg <= col_reg;
            end else if (cmd.start_inc) begin
                start_reg <= start_reg + 1'b1;
            end
        end
    end

    assign x0 = {cfg.origin_x[9], cfg.origin_x};
    assign px = x0 + 11'(col_reg);
    assign xs = x0 + 11'(start_reg);
    assign xe = px - 11'd1;

    // request staging: one pending slot holds back the final-request flag
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = cmd.emit_win || cmd.emit_data;
    assign flush_go = cmd.flush && pend_valid_reg && out_free;

    always_comb begin
        new_res            = '0;
        new_res.screen_row = screen_row_reg;
        if (cmd.emit_data) begin
            new_res.kind      = KIND_DATA;
            new_res.byte_high = rd_data_reg[15:8];
            new_res.byte_low  = rd_data_reg[7:0];
        end else begin
            new_res.kind    = KIND_WINDOW;
            new_res.x_start = xs[7:0];
            new_res.x_end   = xe[7:0];
        end
    end

    always_comb begin
        flush_res      = pend_reg;
        flush_res.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else if (emit) begin
            pend_valid_reg <= 1'b1;
            if (pend_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end else if (flush_go) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pend_reg <= new_res;
            if (pend_valid_reg) out_reg <= pend_reg;
        end else if (flush_go) begin
            out_reg <= flush_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = out_reg;

    assign sts.scan_go    = row_end && py_on;
    assign sts.col_done   = (col_reg >= eff_w);
    assign sts.draw       = !px[10] && (px < SCREEN_LIM) &&
                            (rd_data_reg != cfg.transparent_key);
    assign sts.emit_ok    = !pend_valid_reg || out_free;
    assign sts.data_last  = ((start_reg + 1'b1) == col_reg);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

endmodule

// ===== rtl/core/color_key_sprite_run_blitter.sv =====
// Color key sprite run blitter, top level. Pixels that do not end a row are stored without a scan.
// An on-screen row end starts a scan: each column is read and checked (a column ending a run
// is checked twice), each run gives a window request and then one data request per pixel,
// each with its own row-store read, and the scan ends by seeing the row end and flushing;
// the row store has a registered read. Synchronous active-low reset clears counters,
// controller, request valids and loads register defaults.
module color_key_sprite_run_blitter #(
    parameter int MAX_WIDTH   = ckb_pkg::MAX_WIDTH_DEF,
    parameter int SCREEN_SIZE = ckb_pkg::SCREEN_SIZE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ckb_pkg::PADDR_W-1:0] paddr,
    input  logic [ckb_pkg::PDATA_W-1:0] pwdata,
    output logic [ckb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_pixel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [7:0]                  m_x_start,
    output logic [7:0]                  m_x_end,
    output logic [7:0]                  m_screen_row,
    output logic [7:0]                  m_byte_high,
    output logic [7:0]                  m_byte_low,
    output logic                        m_last
);
    import ckb_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    res_t res;

    ckb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ckb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    ckb_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SCREEN_SIZE (SCREEN_SIZE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .s_valid (s_valid),
        .s_pixel (s_pixel),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign s_ready      = cmd.load;
    assign m_kind       = res.kind;
    assign m_x_start    = res.x_start;
    assign m_x_end      = res.x_end;
    assign m_screen_row = res.screen_row;
    assign m_byte_high  = res.byte_high;
    assign m_byte_low   = res.byte_low;
    assign m_last       = res.last;

endmodule

// ===== sim/color_key_sprite_run_blitter_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for color_key_sprite_run_blitter: directed rows, then random sprites.
// Run predictor, APB register writes and valid/ready drivers with random stalls live here.
// Depends only on ckb_pkg and the top level of the block.
module color_key_sprite_run_blitter_test;
    import ckb_pkg::*;

    localparam int QUIET_CYCLES = 120;
    localparam int LIMIT_CYCLES = 600000;
    localparam res_t NO_REQ = '0;

    typedef enum logic {STEP_REG, STEP_PIXEL} step_kind_t;

    typedef struct {
        step_kind_t op;
        logic [2:0] idx;
        logic [31:0] value;
        logic typed;
        int n_typed;
        res_t typed_res [2];
    } step_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_pixel = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_kind;
    logic [7:0] m_x_start;
    logic [7:0] m_x_end;
    logic [7:0] m_screen_row;
    logic [7:0] m_byte_high;
    logic [7:0] m_byte_low;
    logic m_last;

    color_key_sprite_run_blitter dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_x_start(m_x_start), .m_x_end(m_x_end), .m_screen_row(m_screen_row),
        .m_byte_high(m_byte_high), .m_byte_low(m_byte_low), .m_last(m_last)
    );

    cfg_t shadow = '{origin_x: '0, origin_y: '0, sprite_width: 6'd32,
                     sprite_height: 8'd1, mirror: 1'b0, transparent_key: '0};
    logic [15:0] row_pixels [MAX_WIDTH_DEF];
    int load_col = 0;
    int load_row = 0;
    res_t fresh [$];
    res_t due [$];
    step_t plan [$];
    int errors = 0;
    int cycles = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    function automatic res_t win_res(input logic [7:0] xs, input logic [7:0] xe,
                                     input logic [7:0] row);
        res_t r;
        r = NO_REQ;
        r.kind = KIND_WINDOW;
        r.x_start = xs;
        r.x_end = xe;
        r.screen_row = row;
        return r;
    endfunction

    function automatic res_t dat_res(input logic [7:0] row, input logic [15:0] pix,
                                     input logic last);
        res_t r;
        r = NO_REQ;
        r.kind = KIND_DATA;
        r.screen_row = row;
        r.byte_high = pix[15:8];
        r.byte_low = pix[7:0];
        r.last = last;
        return r;
    endfunction

    function automatic step_t reg_step(input logic [2:0] idx, input logic [31:0] value);
        step_t s;
        s.op = STEP_REG;
        s.idx = idx;
        s.value = value;
        s.typed = 1'b0;
        s.n_typed = 0;
        return s;
    endfunction

    function automatic step_t pix_step(input logic [15:0] pix);
        step_t s;
        s.op = STEP_PIXEL;
        s.idx = '0;
        s.value = 32'(pix);
        s.typed = 1'b0;
        s.n_typed = 0;
        return s;
    endfunction

    function automatic step_t pix_typed(input logic [15:0] pix, input int n,
                                        input res_t r0, input res_t r1);
        step_t s;
        s = pix_step(pix);
        s.typed = 1'b1;
        s.n_typed = n;
        s.typed_res[0] = r0;
        s.typed_res[1] = r1;
        return s;
    endfunction

    function automatic int eff_width();
        if (shadow.sprite_width == 0) return 1;
        if (shadow.sprite_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(shadow.sprite_width);
    endfunction

    function automatic logic [15:0] dest_pixel(input int col, input int w);
        return row_pixels[shadow.mirror ? w - 1 - col : col];
    endfunction

    function automatic logic drawable(input int x0, input int col, input int w);
        return (x0 + col >= 0) && (x0 + col < SCREEN_SIZE_DEF) &&
               (dest_pixel(col, w) != shadow.transparent_key);
    endfunction

    // Loads one pixel into the row copy; on a visible row end, splits it into runs.
    function automatic void blit_pixel(input logic [15:0] pix);
        int w, h, py, x0, col, stop;
        fresh.delete();
        w = eff_width();
        h = (shadow.sprite_height == 0) ? 1 : int'(shadow.sprite_height);
        if (load_col >= w) load_col = 0;
        row_pixels[load_col] = pix;
        load_col++;
        if (load_col < w) return;
        load_col = 0;
        py = int'($signed(shadow.origin_y)) + load_row;
        load_row = (load_row + 1 >= h) ? 0 : load_row + 1;
        if (py < 0 || py >= SCREEN_SIZE_DEF) return;
        x0 = int'($signed(shadow.origin_x));
        col = 0;
        while (col < w) begin
            if (!drawable(x0, col, w)) begin
                col++;
                continue;
            end
            stop = col;
            while (stop < w && drawable(x0, stop, w)) stop++;
            fresh.push_back(win_res(8'(x0 + col), 8'(x0 + stop - 1), 8'(py)));
            while (col < stop) begin
                fresh.push_back(dat_res(8'(py), dest_pixel(col, w), 1'b0));
                col++;
            end
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid !== 1'b0 && m_ready) begin
            if (due.size() == 0) begin
                $display("%0t: unexpected request, expected none, actual kind %0b row %0d",
                         $time, m_kind, m_screen_row);
                errors++;
            end else begin
                want = due.pop_front();
                check_field("kind", 8'(want.kind), 8'(m_kind));
                check_field("x_start", want.x_start, m_x_start);
                check_field("x_end", want.x_end, m_x_end);
                check_field("screen_row", want.screen_row, m_screen_row);
                check_field("byte_high", want.byte_high, m_byte_high);
                check_field("byte_low", want.byte_low, m_byte_low);
                check_field("last", 8'(want.last), 8'(m_last));
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN_X: shadow.origin_x = value[9:0];
            REG_ORIGIN_Y: shadow.origin_y = value[9:0];
            REG_WIDTH: shadow.sprite_width = value[5:0];
            REG_HEIGHT: shadow.sprite_height = value[7:0];
            REG_MIRROR: shadow.mirror = value[0];
            REG_KEY: shadow.transparent_key = value[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Sender holds off until every request has drained and the scan has had time to finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (due.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic feed(input step_t s);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= s.value[15:0];
        do @(posedge aclk); while (!s_ready);
        blit_pixel(s.value[15:0]);
        if (s.typed) begin
            for (int k = 0; k < s.n_typed; k++) due.push_back(s.typed_res[k]);
        end else begin
            foreach (fresh[k]) due.push_back(fresh[k]);
        end
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h200;
            1: return 32'h1FF;
            2: return 32'd239;
            3: return 32'd240;
            default: return 32'(10'($urandom_range(279) - 40));
        endcase
    endfunction

    function automatic logic [31:0] pick_width();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd63;
            2: return 32'd32;
            3: return 32'($urandom_range(62, 33));
            default: return 32'($urandom_range(10, 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_height();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'd255;
            default: return 32'($urandom_range(6, 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_pixel();
        return ($urandom_range(3) == 0) ? shadow.transparent_key : 16'($urandom);
    endfunction

    initial begin
        int w;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        plan.push_back(pix_typed(16'hFFFF, 0, NO_REQ, NO_REQ));
        // width shrunk mid-row: the partial row is dropped
        plan.push_back(reg_step(REG_WIDTH, 32'd1));
        plan.push_back(pix_typed(16'h1234, 2, win_res(8'd0, 8'd0, 8'd0),
                                 dat_res(8'd0, 16'h1234, 1'b1)));
        plan.push_back(pix_typed(16'h0000, 0, NO_REQ, NO_REQ));
        plan.push_back(reg_step(REG_KEY, 32'hFFFF));
        plan.push_back(pix_typed(16'hFFFF, 0, NO_REQ, NO_REQ));
        plan.push_back(pix_typed(16'h0000, 2, win_res(8'd0, 8'd0, 8'd0),
                                 dat_res(8'd0, 16'h0000, 1'b1)));
        plan.push_back(reg_step(REG_WIDTH, 32'd0));
        plan.push_back(pix_typed(16'hABCD, 2, win_res(8'd0, 8'd0, 8'd0),
                                 dat_res(8'd0, 16'hABCD, 1'b1)));
        plan.push_back(reg_step(REG_ORIGIN_Y, 32'd239));
        plan.push_back(pix_typed(16'h5A5A, 2, win_res(8'd0, 8'd0, 8'd239),
                                 dat_res(8'd239, 16'h5A5A, 1'b1)));
        plan.push_back(reg_step(REG_ORIGIN_X, 32'h1FF));
        plan.push_back(pix_typed(16'h1111, 0, NO_REQ, NO_REQ));
        plan.push_back(reg_step(REG_ORIGIN_X, 32'h200));
        plan.push_back(pix_typed(16'h2222, 0, NO_REQ, NO_REQ));
        plan.push_back(reg_step(REG_ORIGIN_X, 32'd239));
        plan.push_back(reg_step(REG_ORIGIN_Y, 32'h200));
        plan.push_back(pix_typed(16'h3333, 0, NO_REQ, NO_REQ));
        plan.push_back(reg_step(REG_ORIGIN_Y, 32'h1FF));
        plan.push_back(pix_typed(16'h4444, 0, NO_REQ, NO_REQ));
        // clipped on the left, mirrored, with a keyed pixel
        plan.push_back(reg_step(REG_ORIGIN_X, 32'h3FE));
        plan.push_back(reg_step(REG_ORIGIN_Y, 32'd0));
        plan.push_back(reg_step(REG_WIDTH, 32'd4));
        plan.push_back(reg_step(REG_HEIGHT, 32'd3));
        plan.push_back(reg_step(REG_MIRROR, 32'd1));
        plan.push_back(reg_step(REG_KEY, 32'd0));
        plan.push_back(pix_step(16'hA1A1));
        plan.push_back(pix_step(16'h0000));
        plan.push_back(pix_step(16'hB2B2));
        plan.push_back(pix_step(16'hC3C3));
        // clipped on the right
        plan.push_back(reg_step(REG_ORIGIN_X, 32'd238));
        plan.push_back(reg_step(REG_MIRROR, 32'd0));
        plan.push_back(pix_step(16'h0001));
        plan.push_back(pix_step(16'h0002));
        plan.push_back(pix_step(16'h0003));
        plan.push_back(pix_step(16'h0004));
        // height shrunk on the last row; two runs split by the key
        plan.push_back(reg_step(REG_HEIGHT, 32'd2));
        plan.push_back(reg_step(REG_ORIGIN_X, 32'd100));
        plan.push_back(pix_step(16'h7E0F));
        plan.push_back(pix_step(16'h0000));
        plan.push_back(pix_step(16'hF800));
        plan.push_back(pix_step(16'h001F));
        plan.push_back(pix_step(16'h0101));
        plan.push_back(pix_step(16'h0202));
        plan.push_back(reg_step(REG_WIDTH, 32'd2));
        plan.push_back(pix_step(16'h0303));
        plan.push_back(pix_step(16'h0404));

        foreach (plan[i]) begin
            if (plan[i].op == STEP_REG) begin
                settle();
                reg_write(plan[i].idx, plan[i].value);
            end else begin
                feed(plan[i]);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_gap_pct = 0; stall_pct = 0; end
                1: begin send_gap_pct = 83; stall_pct = 0; end
                2: begin send_gap_pct = 0; stall_pct = 83; end
                default: begin send_gap_pct = 26; stall_pct = 26; end
            endcase
            for (int set = 0; set < 3; set++) begin
                settle();
                if (ph == 0 && set == 0) begin
                    reg_write(REG_ORIGIN_X, 32'd208);
                    reg_write(REG_ORIGIN_Y, 32'd239);
                    reg_write(REG_WIDTH, 32'd63);
                    reg_write(REG_HEIGHT, 32'd255);
                    reg_write(REG_MIRROR, 32'd1);
                    reg_write(REG_KEY, 32'hFFFF);
                end else begin
                    reg_write(REG_ORIGIN_X, pick_coord());
                    reg_write(REG_ORIGIN_Y, pick_coord());
                    reg_write(REG_WIDTH, pick_width());
                    reg_write(REG_HEIGHT, pick_height());
                    reg_write(REG_MIRROR, 32'($urandom_range(1)));
                    reg_write(REG_KEY, 32'($urandom_range(65535)));
                end
                w = eff_width();
                repeat (((20 + w - 1) / w) * w) feed(pix_step(pick_pixel()));
            end
        end

        settle();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ckb_pkg.sv
rtl/core/ckb_regs.sv
rtl/core/ckb_ctrl.sv
rtl/core/ckb_dp.sv
rtl/core/color_key_sprite_run_blitter.sv
sim/color_key_sprite_run_blitter_test.sv
